// ===== rtl/core/umx_pkg.sv =====
// Shared types, constants and code templates for the UM to x86-64 translator.
// Used by every module of the block; depends on nothing else.
package umx_pkg;

	localparam int unsigned CHUNK_BYTES_DEF = 13;
	localparam int unsigned CHUNK_BYTES_MAX = 32;
	localparam int unsigned TMPL_LEN        = 13;
	localparam int unsigned TMPL_IDX_W      = $clog2(TMPL_LEN);
	localparam int unsigned IDX_W           = $clog2(CHUNK_BYTES_MAX);
	localparam int unsigned NUM_SELS        = 8;
	localparam int unsigned CFG_IDX_W       = 8;
	localparam int unsigned QUEUE_DEPTH_DEF = 2;

	typedef logic [7:0]  u8_t;
	typedef logic [31:0] word_t;
	typedef logic [NUM_SELS-1:0][7:0] sel_bank_t;
	typedef logic [0:TMPL_LEN-1][7:0] tmpl_t;

	// A completed instruction word moving between the front, the queue and the back.
	typedef struct packed {
		logic  valid;
		word_t word;
	} word_slot_t;

	// Helper selector register indexes.
	localparam logic [2:0] SEL_SEG_LOAD     = 3'd0;
	localparam logic [2:0] SEL_SEG_STORE    = 3'd1;
	localparam logic [2:0] SEL_HALT         = 3'd2;
	localparam logic [2:0] SEL_MAP          = 3'd3;
	localparam logic [2:0] SEL_UNMAP        = 3'd4;
	localparam logic [2:0] SEL_OUTPUT       = 3'd5;
	localparam logic [2:0] SEL_INPUT        = 3'd6;
	localparam logic [2:0] SEL_LOAD_PROGRAM = 3'd7;

	localparam sel_bank_t SEL_RESET = {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};

	// Universal Machine opcodes.
	localparam logic [3:0] OP_CMOV    = 4'd0;
	localparam logic [3:0] OP_SEGLOAD = 4'd1;
	localparam logic [3:0] OP_SEGSTOR = 4'd2;
	localparam logic [3:0] OP_ADD     = 4'd3;
	localparam logic [3:0] OP_MUL     = 4'd4;
	localparam logic [3:0] OP_DIV     = 4'd5;
	localparam logic [3:0] OP_NAND    = 4'd6;
	localparam logic [3:0] OP_HALT    = 4'd7;
	localparam logic [3:0] OP_MAP     = 4'd8;
	localparam logic [3:0] OP_FREESEG = 4'd9;
	localparam logic [3:0] OP_OUTPUT  = 4'd10;
	localparam logic [3:0] OP_INPUT   = 4'd11;
	localparam logic [3:0] OP_LOADPRG = 4'd12;
	localparam logic [3:0] OP_LOADVAL = 4'd13;

	// Three-byte nop (0F 1F 00) used as padding inside templates.
	localparam logic [23:0] NOP3 = 24'h0F1F00;

	// Full code template of one instruction word; byte 0 is emitted first.
	function automatic tmpl_t build_tmpl(word_t w, sel_bank_t sel);
		tmpl_t      t;
		logic [3:0] op;
		logic [2:0] a, b, c, ra, mv, kp;
		u8_t        s;
		op = w[31:28];
		a  = w[8:6];
		b  = w[5:3];
		c  = w[2:0];
		ra = w[27:25];
		mv = (a == c) ? c : b;
		kp = (a == c) ? b : c;
		s  = (op == OP_FREESEG) ? sel[SEL_UNMAP] : sel[SEL_OUTPUT];
		t  = '0;
		unique case (op) inside
			OP_CMOV: begin
				t = {8'h45, 8'h85, {2'b11, c, c}, 8'h45, 8'h0F, 8'h45, {2'b11, a, b},
					NOP3, NOP3};
			end
			OP_SEGLOAD: begin
				t = {8'h44, 8'h89, {2'b11, b, 3'b111}, 8'h44, 8'h89, {2'b11, c, 3'b110},
					8'hB0, sel[SEL_SEG_LOAD], 8'hFF, 8'hD3, 8'h41, 8'h89, {5'b11000, a}};
			end
			OP_SEGSTOR: begin
				t = {8'h44, 8'h89, {2'b11, a, 3'b111}, 8'h44, 8'h89, {2'b11, b, 3'b110},
					8'h44, 8'h89, {2'b11, c, 3'b010},
					8'hB0, sel[SEL_SEG_STORE], 8'hFF, 8'hD3};
			end
			OP_ADD: begin
				t = {8'h44, 8'h89, {2'b11, b, 3'b000}, 8'h44, 8'h01, {2'b11, c, 3'b000},
					8'h41, 8'h89, {5'b11000, a}, 8'h90, NOP3};
			end
			OP_MUL: begin
				t = {8'h44, 8'h89, {2'b11, b, 3'b000}, 8'h41, 8'hF7, {5'b11100, c},
					8'h41, 8'h89, {5'b11000, a}, 8'h90, NOP3};
			end
			OP_DIV: begin
				t = {8'h31, 8'hD2, 8'h44, 8'h89, {2'b11, b, 3'b000}, 8'h49, 8'hF7,
					{5'b11110, c}, 8'h41, {5'b10010, a}, NOP3};
			end
			OP_NAND: begin
				// When A equals C the operands trade places so A is read before written.
				t = {8'h45, 8'h8B, {2'b11, a, mv}, 8'h45, 8'h23, {2'b11, a, kp},
					8'h41, 8'hF7, {5'b11010, a}, 8'h90, NOP3};
			end
			OP_HALT: begin
				t = {8'hB0, sel[SEL_HALT], 8'hFF, 8'hE3, 72'h0};
			end
			OP_MAP: begin
				t = {8'h44, 8'h89, {2'b11, c, 3'b111}, 8'hB0, sel[SEL_MAP], 8'hFF, 8'hD3,
					8'h41, 8'h89, {5'b11000, b}, NOP3};
			end
			OP_FREESEG, OP_OUTPUT: begin
				t = {8'h44, 8'h89, {2'b11, c, 3'b111}, 8'hB0, s, 8'hFF, 8'hD3, NOP3, NOP3};
			end
			OP_INPUT: begin
				t = {8'hB0, sel[SEL_INPUT], 8'hFF, 8'hD3, 8'h41, 8'h89, {5'b11000, c},
					NOP3, NOP3};
			end
			OP_LOADPRG: begin
				t = {8'h44, 8'h89, {2'b11, c, 3'b110}, 8'h44, 8'h89, {2'b11, b, 3'b111},
					8'hB0, sel[SEL_LOAD_PROGRAM], 8'hFF, 8'hE3, 24'h0};
			end
			OP_LOADVAL: begin
				// 25-bit immediate stored little-endian in four bytes.
				t = {8'h41, 8'hC7, {5'b11000, ra}, w[7:0], w[15:8], w[23:16],
					{7'd0, w[24]}, NOP3, NOP3};
			end
			default: begin
				t = '0;
			end
		endcase
		return t;
	endfunction

	// One byte of the chunk; positions past the template are zero padding.
	function automatic u8_t pick_byte(word_t w, sel_bank_t sel, logic [IDX_W-1:0] idx);
		tmpl_t t;
		u8_t   r;
		t = build_tmpl(w, sel);
		r = '0;
		if (idx < IDX_W'(TMPL_LEN)) begin
			r = t[idx[TMPL_IDX_W-1:0]];
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/umx_front.sv =====
// Front end: gathers big-endian program bytes into 32-bit instruction words.
// Depends on umx_pkg; feeds umx_queue.
module umx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               prog_valid,
	output logic               prog_stall,
	input  logic [7:0]         prog_byte,
	input  logic               q_full,
	output umx_pkg::word_slot_t push
);

	logic [1:0]  phase_q;
	logic [23:0] partial_q;
	logic        accept;
	logic        last_byte;

	assign last_byte  = (phase_q == 2'd3);
	// Only the fourth byte needs room in the queue.
	assign prog_stall = last_byte && q_full;
	assign accept     = prog_valid && !prog_stall;

	assign push.valid = accept && last_byte;
	assign push.word  = {partial_q, prog_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			partial_q <= '0;
		end else if (accept) begin
			phase_q <= phase_q + 2'd1;
			if (last_byte) begin
				partial_q <= '0;
			end else begin
				partial_q <= {partial_q[15:0], prog_byte};
			end
		end
	end

endmodule

// ===== rtl/core/umx_queue.sv =====
// Short word queue between the front end and the code emitter.
// Depends on umx_pkg; sits between umx_front and umx_back.
module umx_queue #(
	parameter int unsigned QUEUE_DEPTH = umx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  umx_pkg::word_slot_t push,
	output logic                full,
	output umx_pkg::word_slot_t head,
	input  logic                pop
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	umx_pkg::word_t  mem_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CW'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.word  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	ap_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count above depth");
	ap_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("push did not raise queue count");
	ap_pop_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not lower queue count");

endmodule

// ===== rtl/core/umx_back.sv =====
// Back end: expands one queued instruction word into its x86-64 code chunk,
// one byte per cycle through an output register unless stalled. Depends on umx_pkg.
module umx_back #(
	parameter int unsigned CHUNK_BYTES = umx_pkg::CHUNK_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  umx_pkg::sel_bank_t  sels,
	input  umx_pkg::word_slot_t head,
	output logic                pop,
	output logic                code_valid,
	input  logic                code_stall,
	output logic [7:0]          code_byte,
	output logic                chunk_end
);

	localparam int unsigned CW = $clog2(CHUNK_BYTES);
	localparam logic [CW-1:0] LAST = CW'(CHUNK_BYTES - 1);

	logic           busy_q;
	umx_pkg::word_t word_q;
	logic [CW-1:0]  cnt_q;
	logic           out_valid_q;
	umx_pkg::u8_t   code_byte_q;
	logic           chunk_end_q;
	logic           adv;
	logic           at_last;

	assign adv     = !out_valid_q || !code_stall;
	assign at_last = (cnt_q == LAST);
	// A new word loads when idle, or as the last byte of the chunk is registered.
	assign pop     = head.valid && (!busy_q || (adv && at_last));

	assign code_valid = out_valid_q;
	assign code_byte  = code_byte_q;
	assign chunk_end  = chunk_end_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			word_q <= head.word;
		end
		if (adv && busy_q) begin
			code_byte_q <= umx_pkg::pick_byte(word_q, sels, umx_pkg::IDX_W'(cnt_q));
			chunk_end_q <= at_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (adv && busy_q) begin
				if (at_last) begin
					busy_q <= 1'b0;
					cnt_q  <= '0;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
		end
	end

	ap_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= LAST)
		else $error("byte counter past end of chunk");
	ap_load_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (busy_q && cnt_q == '0))
		else $error("loaded word did not restart the chunk");
	ap_last_marks_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && busy_q && at_last) |=> (out_valid_q && chunk_end_q))
		else $error("last byte of chunk not marked");
	ap_end_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && busy_q && !at_last) |=> (out_valid_q && !chunk_end_q))
		else $error("chunk end marked early");

endmodule

// ===== rtl/core/um_to_x86_code_translator.sv =====
// Top level of the UM to x86-64 code translator: config registers and the
// front, queue and back parts. Depends on umx_pkg, umx_front, umx_queue, umx_back.
//
// Usage: program bytes enter on prog_valid/prog_stall/prog_byte, most significant
// byte of each 32-bit instruction word first. Every fourth byte completes a word,
// which becomes a chunk of CHUNK_BYTES x86-64 code bytes on code_valid/code_stall,
// one byte per item, with chunk_end high on the final byte of each chunk.
// The output is one code byte per cycle while code_stall is low, set by the single
// byte counter of the back end, so the rate of the chunk output paces sustained
// input. A completed word passes through the queue, then the word register of
// the back end, then the output register, before the first code byte of its
// chunk is valid, if the back end is free.
// The front end takes bytes of the next word while a chunk is still streaming;
// a short queue of completed words lets the two sides stall independently. Only
// the fourth byte of a word can be stalled, when that queue is full.
// When the receiver raises code_stall the output register holds its byte and
// the back end waits; the front end keeps filling the queue.
// Reset clears the byte phase, the queue and the output valid flag and sets the
// helper selectors to 0 through 7; no clearing pass follows. Configuration
// writes (cfg_valid with cfg_ready, always ready) are never held off; indexes of
// 8 and above are ignored.
module um_to_x86_code_translator #(
	parameter int unsigned CHUNK_BYTES = umx_pkg::CHUNK_BYTES_DEF,
	parameter int unsigned QUEUE_DEPTH = umx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          prog_valid,
	output logic                          prog_stall,
	input  logic [7:0]                    prog_byte,
	output logic                          code_valid,
	input  logic                          code_stall,
	output logic [7:0]                    code_byte,
	output logic                          chunk_end,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [umx_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	umx_pkg::sel_bank_t  sels_q;
	umx_pkg::word_slot_t push;
	umx_pkg::word_slot_t head;
	logic                q_full;
	logic                pop;

	// Selector registers; the write port never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sels_q <= umx_pkg::SEL_RESET;
		end else if (cfg_valid && cfg_ready
				&& cfg_index < umx_pkg::CFG_IDX_W'(umx_pkg::NUM_SELS)) begin
			sels_q[cfg_index[$clog2(umx_pkg::NUM_SELS)-1:0]] <= cfg_data;
		end
	end

	// Byte gathering.
	umx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.prog_valid(prog_valid),
		.prog_stall(prog_stall),
		.prog_byte (prog_byte),
		.q_full    (q_full),
		.push      (push)
	);

	// Decoupling queue of completed words.
	umx_queue #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (q_full),
		.head  (head),
		.pop   (pop)
	);

	// Chunk emission.
	umx_back #(
		.CHUNK_BYTES(CHUNK_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sels      (sels_q),
		.head      (head),
		.pop       (pop),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_byte (code_byte),
		.chunk_end (chunk_end)
	);

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the UM to x86-64 code translator: program bytes in,
// code bytes out. Depends on umx_pkg and um_to_x86_code_translator. A predictor inside
// the bench translates each completed word into its code chunk and checks every byte.
module testbench;

	// Chunk size used for the build under test.
	localparam int unsigned CHUNK = umx_pkg::CHUNK_BYTES_DEF;
	// Cycles without any accepted item before the run is given up.
	localparam int unsigned STALL_LIMIT = 2000;
	// Quiet cycles after the last code byte, well beyond the latency of the block.
	localparam int unsigned SETTLE_CYCLES = 20;
	// Chance in a hundred that a side idles in a given cycle.
	localparam int unsigned IDLE_PCT = 26;

	// One expected output item: a code byte and its end-of-chunk flag.
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} code_item_t;

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          prog_valid = 1'b0;
	logic                          prog_stall;
	logic [7:0]                    prog_byte  = 8'h00;
	logic                          code_valid;
	logic                          code_stall = 1'b0;
	logic [7:0]                    code_byte;
	logic                          chunk_end;
	logic                          cfg_valid  = 1'b0;
	logic                          cfg_ready;
	logic [umx_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
	logic [7:0]                    cfg_data   = 8'h00;

	// Bench copy of the block's state and selector bank.
	logic [1:0]  word_phase;
	logic [23:0] word_so_far;
	logic [7:0]  sel_copy [0:umx_pkg::NUM_SELS-1];

	// Code bytes predicted but not yet seen, oldest first.
	code_item_t pending_code_bytes [$];

	// Scratch chunk filled by the predictor.
	logic [7:0]  chunk_buf [0:CHUNK-1];
	int unsigned chunk_fill;

	// When low, both sides run back to back with no idle cycles.
	bit          pace_on = 1'b1;
	int unsigned mismatches = 0;
	int unsigned bytes_sent = 0;
	int unsigned bytes_checked = 0;
	int unsigned sel_writes = 0;
	int unsigned words_sent = 0;
	int unsigned quiet_cycles = 0;
	// Opcode for the next random word; it walks through all sixteen in turn.
	logic [3:0]  op_cursor = 4'd0;

	always #1 clk = ~clk;

	um_to_x86_code_translator #(
		.CHUNK_BYTES(CHUNK)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.prog_valid(prog_valid),
		.prog_stall(prog_stall),
		.prog_byte (prog_byte),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_byte (code_byte),
		.chunk_end (chunk_end),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// ------------------------------------------------------------------
	// Predictor: builds the chunk for one word the way the translator must.
	// ------------------------------------------------------------------

	// Appends one byte to the chunk; anything past the chunk size is dropped.
	function automatic void put_byte(input logic [7:0] b);
		if (chunk_fill < CHUNK) begin
			chunk_buf[chunk_fill] = b;
		end
		chunk_fill++;
	endfunction

	// Three-byte nop used as template padding.
	function automatic void put_nop3();
		put_byte(8'h0F);
		put_byte(8'h1F);
		put_byte(8'h00);
	endfunction

	// Loads the helper selector into al, then calls or jumps through the helper table.
	function automatic void put_helper(input logic [7:0] sel, input logic [7:0] kind);
		put_byte(8'hB0);
		put_byte(sel);
		put_byte(8'hFF);
		put_byte(kind);
	endfunction

	// Translates one completed word and queues its chunk, one item per code byte.
	function automatic void translate_word(input logic [31:0] w);
		logic [3:0]  op;
		logic [2:0]  ra, rb, rc, la, mv, kp;
		logic [24:0] imm;
		int unsigned i;
		op  = w[31:28];
		ra  = w[8:6];
		rb  = w[5:3];
		rc  = w[2:0];
		la  = w[27:25];
		imm = w[24:0];
		// NAND with A equal to C moves C first and then ANDs with B.
		mv  = (ra == rc) ? rc : rb;
		kp  = (ra == rc) ? rb : rc;
		chunk_fill = 0;
		for (i = 0; i < CHUNK; i++) begin
			chunk_buf[i] = 8'h00;
		end
		case (op)
			umx_pkg::OP_CMOV: begin
				put_byte(8'h45); put_byte(8'h85); put_byte({2'b11, rc, rc});
				put_byte(8'h45); put_byte(8'h0F); put_byte(8'h45); put_byte({2'b11, ra, rb});
				put_nop3(); put_nop3();
			end
			umx_pkg::OP_SEGLOAD: begin
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rb, 3'b111});
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rc, 3'b110});
				put_helper(sel_copy[umx_pkg::SEL_SEG_LOAD], 8'hD3);
				put_byte(8'h41); put_byte(8'h89); put_byte({5'b11000, ra});
			end
			umx_pkg::OP_SEGSTOR: begin
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, ra, 3'b111});
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rb, 3'b110});
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rc, 3'b010});
				put_helper(sel_copy[umx_pkg::SEL_SEG_STORE], 8'hD3);
			end
			umx_pkg::OP_ADD, umx_pkg::OP_MUL: begin
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rb, 3'b000});
				if (op == umx_pkg::OP_ADD) begin
					put_byte(8'h44); put_byte(8'h01); put_byte({2'b11, rc, 3'b000});
				end else begin
					put_byte(8'h41); put_byte(8'hF7); put_byte({5'b11100, rc});
				end
				put_byte(8'h41); put_byte(8'h89); put_byte({5'b11000, ra});
				put_byte(8'h90);
				put_nop3();
			end
			umx_pkg::OP_DIV: begin
				put_byte(8'h31); put_byte(8'hD2);
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rb, 3'b000});
				put_byte(8'h49); put_byte(8'hF7); put_byte({5'b11110, rc});
				put_byte(8'h41); put_byte({5'b10010, ra});
				put_nop3();
			end
			umx_pkg::OP_NAND: begin
				put_byte(8'h45); put_byte(8'h8B); put_byte({2'b11, ra, mv});
				put_byte(8'h45); put_byte(8'h23); put_byte({2'b11, ra, kp});
				put_byte(8'h41); put_byte(8'hF7); put_byte({5'b11010, ra});
				put_byte(8'h90);
				put_nop3();
			end
			umx_pkg::OP_HALT: begin
				put_helper(sel_copy[umx_pkg::SEL_HALT], 8'hE3);
			end
			umx_pkg::OP_MAP: begin
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rc, 3'b111});
				put_helper(sel_copy[umx_pkg::SEL_MAP], 8'hD3);
				put_byte(8'h41); put_byte(8'h89); put_byte({5'b11000, rb});
				put_nop3();
			end
			umx_pkg::OP_FREESEG, umx_pkg::OP_OUTPUT: begin
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rc, 3'b111});
				put_helper((op == umx_pkg::OP_FREESEG) ? sel_copy[umx_pkg::SEL_UNMAP]
					: sel_copy[umx_pkg::SEL_OUTPUT], 8'hD3);
				put_nop3(); put_nop3();
			end
			umx_pkg::OP_INPUT: begin
				put_helper(sel_copy[umx_pkg::SEL_INPUT], 8'hD3);
				put_byte(8'h41); put_byte(8'h89); put_byte({5'b11000, rc});
				put_nop3(); put_nop3();
			end
			umx_pkg::OP_LOADPRG: begin
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rc, 3'b110});
				put_byte(8'h44); put_byte(8'h89); put_byte({2'b11, rb, 3'b111});
				put_helper(sel_copy[umx_pkg::SEL_LOAD_PROGRAM], 8'hE3);
			end
			umx_pkg::OP_LOADVAL: begin
				// The 25-bit immediate goes out least significant byte first.
				put_byte(8'h41); put_byte(8'hC7); put_byte({5'b11000, la});
				put_byte(imm[7:0]); put_byte(imm[15:8]); put_byte(imm[23:16]);
				put_byte({7'd0, imm[24]});
				put_nop3(); put_nop3();
			end
			default: begin
				// Opcodes fourteen and fifteen leave the chunk all zero.
			end
		endcase
		for (i = 0; i < CHUNK; i++) begin
			pending_code_bytes.push_back('{code: chunk_buf[i], last: (i == CHUNK - 1)});
		end
	endfunction

	// ------------------------------------------------------------------
	// Shared stimulus tasks.
	// ------------------------------------------------------------------

	// Offers one program byte, holding it until accepted, then updates the bench state.
	// Valid is left high so that a following byte can go out in the very next cycle.
	task automatic send_byte(input logic [7:0] b);
		if (pace_on) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				prog_valid <= 1'b0;
				@(posedge clk);
			end
		end
		prog_valid <= 1'b1;
		prog_byte  <= b;
		do begin
			@(posedge clk);
		end while (prog_stall);
		bytes_sent++;
		if (word_phase < 2'd3) begin
			word_so_far = {word_so_far[15:0], b};
			word_phase++;
		end else begin
			words_sent++;
			translate_word({word_so_far, b});
			word_phase  = 2'd0;
			word_so_far = 24'h0;
		end
	endtask

	// Sends a word most significant byte first.
	task automatic send_word(input logic [31:0] w);
		send_byte(w[31:24]);
		send_byte(w[23:16]);
		send_byte(w[15:8]);
		send_byte(w[7:0]);
	endtask

	// Sends words whose opcodes walk through all sixteen values, with random register
	// fields and random spare bits. About half of the NAND words get A equal to C.
	task automatic send_random_words(input int unsigned count);
		logic [31:0] w;
		int unsigned k;
		for (k = 0; k < count; k++) begin
			w = $urandom();
			w[31:28] = op_cursor;
			if (op_cursor == umx_pkg::OP_NAND && $urandom_range(0, 1) == 1) begin
				w[2:0] = w[8:6];
			end
			op_cursor++;
			send_word(w);
		end
	endtask

	// Lowers the program valid after the last byte of a phase.
	task automatic end_program();
		prog_valid <= 1'b0;
	endtask

	// Waits until every predicted code byte has come out, then lets the block settle.
	// Selector writes are only made after this.
	task automatic wait_drained();
		while (pending_code_bytes.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// Writes one selector register. Valid stays high so writes can follow back to back;
	// end_selector_writes lowers it.
	task automatic write_selector(input logic [umx_pkg::CFG_IDX_W-1:0] idx,
			input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		sel_writes++;
		// Indexes past the bank are accepted by the port but change nothing.
		if (idx < umx_pkg::NUM_SELS) begin
			sel_copy[idx] = val;
		end
	endtask

	task automatic end_selector_writes();
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Test tasks.
	// ------------------------------------------------------------------

	// Under the reset selectors: short templates, the all-ones word, a word with zero registers,
	// a full-size immediate, NAND with A equal to C, and the two empty opcodes.
	task automatic test_reset_selectors();
		send_word(32'h7FFF_FFFF);   // halt, every field bit set
		send_word(32'hB000_0000);   // input, all registers zero
		send_word(32'hC000_01FF);   // load program, all registers seven
		send_word(32'hDFFF_FFFF);   // load value, A seven, largest immediate
		send_word(32'h6000_01C7);   // NAND with A and C both seven, B zero
		send_word(32'hE000_0000);   // opcode fourteen
		send_word(32'hFFFF_FFFF);   // opcode fifteen
		end_program();
		wait_drained();
	endtask

	// Every selector at its top value, plus writes to indexes past the bank that
	// must leave the selectors alone.
	task automatic test_selectors_high();
		int unsigned i;
		for (i = 0; i < umx_pkg::NUM_SELS; i++) begin
			write_selector(umx_pkg::CFG_IDX_W'(i), 8'hFF);
		end
		write_selector(umx_pkg::CFG_IDX_W'(umx_pkg::NUM_SELS), 8'h00);
		write_selector({umx_pkg::CFG_IDX_W{1'b1}}, 8'h00);
		end_selector_writes();
		send_random_words(8);
		end_program();
		wait_drained();
	endtask

	// Every selector zero, with both sides running flat out the whole time.
	task automatic test_selectors_zero_no_idle();
		int unsigned i;
		for (i = 0; i < umx_pkg::NUM_SELS; i++) begin
			write_selector(umx_pkg::CFG_IDX_W'(i), 8'h00);
		end
		end_selector_writes();
		pace_on = 1'b0;
		send_random_words(8);
		end_program();
		wait_drained();
		pace_on = 1'b1;
	endtask

	// Random selector values in random order, some indexes out of range.
	task automatic test_selectors_random();
		int unsigned i;
		for (i = 0; i < 12; i++) begin
			write_selector(umx_pkg::CFG_IDX_W'($urandom_range(0, umx_pkg::NUM_SELS + 3)),
				8'($urandom()));
		end
		end_selector_writes();
		send_random_words(8);
		end_program();
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Output side: random stall and the byte-by-byte check.
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		if (pace_on) begin
			code_stall <= ($urandom_range(0, 99) < IDLE_PCT);
		end else begin
			code_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		code_item_t want;
		if (arst_n && code_valid && !code_stall) begin
			if (pending_code_bytes.size() == 0) begin
				$error("unexpected code byte %02h with chunk_end %0b", code_byte, chunk_end);
				mismatches++;
			end else begin
				want = pending_code_bytes.pop_front();
				bytes_checked++;
				if (code_byte !== want.code) begin
					$error("code_byte: expected %02h, got %02h", want.code, code_byte);
					mismatches++;
				end
				if (chunk_end !== want.last) begin
					$error("chunk_end: expected %0b, got %0b", want.last, chunk_end);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a hang shows up as a long run of cycles in which no handshake completes.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((prog_valid && !prog_stall) || (code_valid && !code_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence of the run.
	// ------------------------------------------------------------------

	initial begin
		int unsigned i;
		word_phase  = 2'd0;
		word_so_far = 24'h0;
		for (i = 0; i < umx_pkg::NUM_SELS; i++) begin
			sel_copy[i] = 8'(i);
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_selectors();
		test_selectors_high();
		test_selectors_zero_no_idle();
		test_selectors_random();

		// Anything the block still emits now has no prediction and is flagged.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_code_bytes.size() != 0) begin
			$error("%0d code bytes never arrived", pending_code_bytes.size());
			mismatches++;
		end

		$display("Sent %0d program bytes (%0d words, all sixteen opcodes), %0d selector writes",
			bytes_sent, words_sent, sel_writes);
		$display("Checked %0d code bytes, %0d mismatches", bytes_checked, mismatches);
		if (mismatches == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/umx_pkg.sv
rtl/core/umx_front.sv
rtl/core/umx_queue.sv
rtl/core/umx_back.sv
rtl/core/um_to_x86_code_translator.sv
tb/testbench.sv
